[src/rwc_pkg.sv]
// rwc_pkg: shared constants for the rotated window crop block
// register indexes, reset values and fixed arithmetic widths; no dependencies
package rwc_pkg;

  // default sizes, handed to the top level parameters
  localparam int SRC_DIM_MAX_DEF = 128;
  localparam int WIN_DIM_MAX_DEF = 40;

  // configuration register indexes
  localparam logic [2:0] REG_SRC_COLS = 3'd0;
  localparam logic [2:0] REG_SRC_ROWS = 3'd1;
  localparam logic [2:0] REG_SHIFT_X  = 3'd2;
  localparam logic [2:0] REG_SHIFT_Y  = 3'd3;
  localparam logic [2:0] REG_COS_Q14  = 3'd4;
  localparam logic [2:0] REG_SIN_Q14  = 3'd5;

  // configuration reset values
  localparam logic [7:0]  SRC_COLS_RST = 8'd128;
  localparam logic [7:0]  SRC_ROWS_RST = 8'd128;
  localparam logic [7:0]  SHIFT_RST    = 8'd0;
  localparam logic [15:0] COS_RST      = 16'sd16384;
  localparam logic [15:0] SIN_RST      = 16'sd0;

  // fixed point
  localparam int FRAC_BITS = 14;
  localparam logic [13:0] Q_HALF = 14'd8192;

  // widths: window coordinate, window size, product, rotated position
  localparam int SXW = 10;
  localparam int DMW = 10;
  localparam int PW  = SXW + 16;
  localparam int XW  = 28;

endpackage

[src/rotated_window_crop.sv]
// rotated_window_crop: nearest neighbour crop of a rotated window from a stored grey image
// depends on rwc_pkg for constants and on rwc_ram for the source image store
//
// path: input, window, product, position, rounding, memory and output registers to out_
// throughput: one word (pixel write or request) per cycle, set by the single image ram
//   access made in the memory stage; stalls on out_ back up stage by stage, bubbles close
// reset: rst_n synchronous active low, clears all valid bits and loads the register reset
//   values; the image store is not cleared and holds nothing defined until written
module rotated_window_crop #(
  parameter int SRC_DIM_MAX = rwc_pkg::SRC_DIM_MAX_DEF,
  parameter int WIN_DIM_MAX = rwc_pkg::WIN_DIM_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request / pixel write channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // col [6:0], row [13:7], in_pixel [21:14], zero [23:22]
  input  logic        in_tuser,   // op: 0 write pixel, 1 request pixel
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_pixel [7:0]
  output logic        out_tuser,  // in_window
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import rwc_pkg::*;

  localparam int IXW   = $clog2(SRC_DIM_MAX);
  localparam int DEPTH = SRC_DIM_MAX * SRC_DIM_MAX;
  localparam int AW    = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------------------
  logic [7:0]  src_cols_r, src_rows_r, shift_x_r, shift_y_r;
  logic [15:0] cos_q14_r, sin_q14_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cols_r <= SRC_COLS_RST;
      src_rows_r <= SRC_ROWS_RST;
      shift_x_r  <= SHIFT_RST;
      shift_y_r  <= SHIFT_RST;
      cos_q14_r  <= COS_RST;
      sin_q14_r  <= SIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_COLS: src_cols_r <= cfg_data[7:0];
        REG_SRC_ROWS: src_rows_r <= cfg_data[7:0];
        REG_SHIFT_X:  shift_x_r  <= cfg_data[7:0];
        REG_SHIFT_Y:  shift_y_r  <= cfg_data[7:0];
        REG_COS_Q14:  cos_q14_r  <= cfg_data;
        REG_SIN_Q14:  sin_q14_r  <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // derived geometry, recomputed every cycle; the block leaves it to the user to change registers only while idle
  // ---------------------------------------------------------------------------
  logic [7:0]            cols_nxt, rows_nxt, cols_r, rows_r;
  logic [7:0]            adx, ady;
  logic signed [DMW-1:0] dimx_raw, dimy_raw, dimx_nxt, dimy_nxt, dimx_r, dimy_r;
  logic [XW-1:0]         cx_nxt, cy_nxt, cx_r, cy_r;

  // image size saturated into 1..SRC_DIM_MAX, zero counts as one
  always_comb begin
    cols_nxt = src_cols_r;
    if (src_cols_r == 8'd0) begin
      cols_nxt = 8'd1;
    end else if (11'(src_cols_r) > 11'(SRC_DIM_MAX)) begin
      cols_nxt = 8'(SRC_DIM_MAX);
    end
    rows_nxt = src_rows_r;
    if (src_rows_r == 8'd0) begin
      rows_nxt = 8'd1;
    end else if (11'(src_rows_r) > 11'(SRC_DIM_MAX)) begin
      rows_nxt = 8'(SRC_DIM_MAX);
    end
  end

  // window size: min(window max, size - 2|shift|), may go to zero or below
  always_comb begin
    adx = shift_x_r[7] ? 8'(-shift_x_r) : shift_x_r;
    ady = shift_y_r[7] ? 8'(-shift_y_r) : shift_y_r;
    dimx_raw = $signed({2'b00, cols_nxt}) - $signed({1'b0, adx, 1'b0});
    dimy_raw = $signed({2'b00, rows_nxt}) - $signed({1'b0, ady, 1'b0});
    dimx_nxt = (dimx_raw > $signed(DMW'(WIN_DIM_MAX))) ? $signed(DMW'(WIN_DIM_MAX)) : dimx_raw;
    dimy_nxt = (dimy_raw > $signed(DMW'(WIN_DIM_MAX))) ? $signed(DMW'(WIN_DIM_MAX)) : dimy_raw;
    // image centre in q14
    cx_nxt = XW'({cols_nxt[7:1], {FRAC_BITS{1'b0}}});
    cy_nxt = XW'({rows_nxt[7:1], {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    cols_r <= cols_nxt;
    rows_r <= rows_nxt;
    dimx_r <= dimx_nxt;
    dimy_r <= dimy_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake: a stage loads when empty or when it moves on
  // ---------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en0, en1, en2, en3, en4, en5, en6;
  logic op5_r;

  assign en6 = !v6_r || out_tready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;

  assign in_tready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      // pixel writes leave the pipe here, only requests give a result word
      if (en6) v6_r <= v5_r && op5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------------
  logic       op0_r;
  logic [6:0] col0_r, row0_r;
  logic [7:0] pix0_r;

  always_ff @(posedge clk) begin
    if (en0) begin
      op0_r  <= in_tuser;
      col0_r <= in_tdata[6:0];
      row0_r <= in_tdata[13:7];
      pix0_r <= in_tdata[21:14];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: window test and window position relative to the image centre
  // ---------------------------------------------------------------------------
  logic                  op1_r, win1_r, win1_nxt;
  logic [6:0]            col1_r, row1_r;
  logic [7:0]            pix1_r;
  logic signed [SXW-1:0] sx1_r, sy1_r, sx1_nxt, sy1_nxt;

  always_comb begin
    win1_nxt = (dimx_r > 0) && (dimy_r > 0) &&
               ($signed({3'b000, col0_r}) < dimx_r) &&
               ($signed({3'b000, row0_r}) < dimy_r);
    // half window truncates, only used while the window is not empty
    sx1_nxt = $signed({3'b000, col0_r}) - (dimx_r >>> 1) + $signed({{2{shift_x_r[7]}}, shift_x_r});
    sy1_nxt = $signed({3'b000, row0_r}) - (dimy_r >>> 1) + $signed({{2{shift_y_r[7]}}, shift_y_r});
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r  <= op0_r;
      col1_r <= col0_r;
      row1_r <= row0_r;
      pix1_r <= pix0_r;
      win1_r <= win1_nxt;
      sx1_r  <= sx1_nxt;
      sy1_r  <= sy1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: four rotation products
  // ---------------------------------------------------------------------------
  logic                 op2_r, win2_r;
  logic [6:0]           col2_r, row2_r;
  logic [7:0]           pix2_r;
  logic signed [PW-1:0] pxc2_r, pys2_r, pxs2_r, pyc2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      op2_r  <= op1_r;
      col2_r <= col1_r;
      row2_r <= row1_r;
      pix2_r <= pix1_r;
      win2_r <= win1_r;
      pxc2_r <= sx1_r * $signed(cos_q14_r);
      pys2_r <= sy1_r * $signed(sin_q14_r);
      pxs2_r <= sx1_r * $signed(sin_q14_r);
      pyc2_r <= sy1_r * $signed(cos_q14_r);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: rotated source position in q14
  // ---------------------------------------------------------------------------
  logic                 op3_r, win3_r;
  logic [6:0]           col3_r, row3_r;
  logic [7:0]           pix3_r;
  logic signed [XW-1:0] x3_r, y3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      op3_r  <= op2_r;
      col3_r <= col2_r;
      row3_r <= row2_r;
      pix3_r <= pix2_r;
      win3_r <= win2_r;
      x3_r   <= XW'(pxc2_r) - XW'(pys2_r) + $signed(cx_r);
      y3_r   <= XW'(pxs2_r) + XW'(pyc2_r) + $signed(cy_r);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: source hit test and rounding to the nearest pixel
  // ---------------------------------------------------------------------------
  logic           op4_r, win4_r, hit4_r, hit4_nxt;
  logic [6:0]     col4_r, row4_r;
  logic [7:0]     pix4_r;
  logic [IXW-1:0] ix4_r, iy4_r;
  logic [7:0]     qx, qy;
  logic [8:0]     qx_up, qy_up, qx_cl, qy_cl;
  logic [13:0]    fx, fy;

  always_comb begin
    hit4_nxt = win3_r && !x3_r[XW-1] && !y3_r[XW-1] &&
               (x3_r < $signed(XW'({cols_r, {FRAC_BITS{1'b0}}}))) &&
               (y3_r < $signed(XW'({rows_r, {FRAC_BITS{1'b0}}})));
    qx = x3_r[FRAC_BITS +: 8];
    qy = y3_r[FRAC_BITS +: 8];
    fx = x3_r[FRAC_BITS-1:0];
    fy = y3_r[FRAC_BITS-1:0];
    // ties go to the even pixel
    qx_up = {1'b0, qx} + 9'((fx > Q_HALF) || ((fx == Q_HALF) && qx[0]));
    qy_up = {1'b0, qy} + 9'((fy > Q_HALF) || ((fy == Q_HALF) && qy[0]));
    // rounding onto the far edge lands on the last column or row
    qx_cl = (qx_up >= {1'b0, cols_r}) ? ({1'b0, cols_r} - 9'd1) : qx_up;
    qy_cl = (qy_up >= {1'b0, rows_r}) ? ({1'b0, rows_r} - 9'd1) : qy_up;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      op4_r  <= op3_r;
      col4_r <= col3_r;
      row4_r <= row3_r;
      pix4_r <= pix3_r;
      win4_r <= win3_r;
      hit4_r <= hit4_nxt;
      ix4_r  <= IXW'(qx_cl);
      iy4_r  <= IXW'(qy_cl);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: image store, writes and reads in stream order at one place
  // ---------------------------------------------------------------------------
  logic          win5_r, hit5_r;
  logic          ram_we, ram_re, wr_ok;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  assign wr_ok     = (11'(col4_r) < 11'(SRC_DIM_MAX)) && (11'(row4_r) < 11'(SRC_DIM_MAX));
  assign ram_we    = en5 && v4_r && !op4_r && wr_ok;
  assign ram_re    = en5 && v4_r && op4_r && hit4_r;
  assign ram_waddr = AW'(32'(row4_r) * SRC_DIM_MAX + 32'(col4_r));
  assign ram_raddr = AW'(32'(iy4_r) * SRC_DIM_MAX + 32'(ix4_r));

  rwc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pix4_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (en5) begin
      op5_r  <= op4_r;
      win5_r <= win4_r;
      hit5_r <= hit4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: output register, zero outside the source or the window
  // ---------------------------------------------------------------------------
  logic [7:0] pix6_r;
  logic       win6_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      pix6_r <= hit5_r ? ram_rdata : 8'd0;
      win6_r <= win5_r;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = pix6_r;
  assign out_tuser  = win6_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_outside_window_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 8'd0)
    else $error("pixel returned for a request outside the window");

  a_window_col_bound : assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && op1_r && win1_r |-> 32'(col1_r) < WIN_DIM_MAX && 32'(row1_r) < WIN_DIM_MAX)
    else $error("window test passed beyond the window size");

  a_index_in_image : assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && op4_r && hit4_r |-> 32'(ix4_r) < 32'(cols_r) && 32'(iy4_r) < 32'(rows_r))
    else $error("rounded index outside the source image");

  a_stall_holds_word : assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !en5 |=> v5_r && $stable(ram_rdata) && $stable(hit5_r))
    else $error("memory stage lost its word during a stall");

endmodule

[src/rwc_ram.sv]
// rwc_ram: generic simple dual port ram, one write and one read port
// read data registered and held while re is low; no dependencies
module rwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[dv/rwc_tb_pkg.sv]
// rwc_tb_pkg: operation codes shared by the rotated window crop testbench files
// no dependencies; used by crop_checker and testbench
package rwc_tb_pkg;

  // carried on in_tuser
  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_REQUEST = 1'b1
  } pixel_op_e;

endpackage

[dv/crop_checker.sv]
// crop_checker: watches the word, register and result channels of rotated_window_crop,
// predicts each result pixel from its own copy of image and registers, and compares
// depends on rwc_pkg (register indexes, reset values) and rwc_tb_pkg (operation codes)
module crop_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // col [6:0], row [13:7], in_pixel [21:14], zero [23:22]
  input  logic        in_tuser,   // op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // out_pixel [7:0]
  input  logic        out_tuser,  // in_window
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          awaiting,
  output int          results_checked
);

  import rwc_pkg::*;
  import rwc_tb_pkg::*;

  localparam int     SRC_DIM = SRC_DIM_MAX_DEF;
  localparam int     WIN_DIM = WIN_DIM_MAX_DEF;
  localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
  localparam longint HALF_Q  = ONE_Q / 2;

  typedef struct packed {
    logic [7:0] grey;
    logic       in_win;
  } crop_px_t;

  logic [7:0]        src_image [SRC_DIM*SRC_DIM];
  logic [7:0]        cols_reg, rows_reg;
  logic signed [7:0] shift_x_reg, shift_y_reg;
  logic signed [15:0] cos_reg, sin_reg;
  crop_px_t          pending_px [$];

  // register value to usable image size, 0 counts as 1
  function automatic longint clamp_size(input logic [7:0] reg_val);
    longint v;
    v = longint'(reg_val);
    if (v < 1) return 1;
    if (v > SRC_DIM) return SRC_DIM;
    return v;
  endfunction

  function automatic longint win_span(input longint size, input longint shift);
    longint d;
    d = size - 2 * (shift < 0 ? -shift : shift);
    return (d < WIN_DIM) ? d : WIN_DIM;
  endfunction

  // nearest integer, ties to even, then pulled back onto the last index
  function automatic longint round_nearest(input longint v, input longint lim);
    longint q, f;
    q = v / ONE_Q;
    f = v % ONE_Q;
    if (f > HALF_Q || (f == HALF_Q && (q % 2) != 0)) q++;
    if (q > lim - 1) q = lim - 1;
    return q;
  endfunction

  function automatic crop_px_t rotated_sample(input longint col, input longint row);
    longint cols, rows, dx, dy, dim_x, dim_y, cs, sn, sx, sy, xq, yq, ix, iy;
    crop_px_t px;
    px = '0;
    cols = clamp_size(cols_reg);
    rows = clamp_size(rows_reg);
    dx = shift_x_reg;
    dy = shift_y_reg;
    dim_x = win_span(cols, dx);
    dim_y = win_span(rows, dy);
    if (dim_x <= 0 || dim_y <= 0 || col >= dim_x || row >= dim_y) return px;
    cs = cos_reg;
    sn = sin_reg;
    sx = col - dim_x / 2 + dx;
    sy = row - dim_y / 2 + dy;
    xq = sx * cs - sy * sn + (cols / 2) * ONE_Q;
    yq = sx * sn + sy * cs + (rows / 2) * ONE_Q;
    px.in_win = 1'b1;
    if (xq >= 0 && yq >= 0 && xq < cols * ONE_Q && yq < rows * ONE_Q) begin
      ix = round_nearest(xq, cols);
      iy = round_nearest(yq, rows);
      px.grey = src_image[iy * SRC_DIM + ix];
    end
    return px;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    crop_px_t want;
    if (!rst_n) begin
      cols_reg = SRC_COLS_RST;
      rows_reg = SRC_ROWS_RST;
      shift_x_reg = SHIFT_RST;
      shift_y_reg = SHIFT_RST;
      cos_reg = COS_RST;
      sin_reg = SIN_RST;
      pending_px.delete();
      mismatches = 0;
      results_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_px.size() == 0) begin
          note_mismatch($sformatf("unexpected result pixel %0d window %0b",
                                  out_tdata, out_tuser));
        end else begin
          want = pending_px.pop_front();
          results_checked++;
          if (out_tdata !== want.grey || out_tuser !== want.in_win)
            note_mismatch($sformatf("pixel exp %0d got %0d, window exp %0b got %0b",
                                    want.grey, out_tdata, want.in_win, out_tuser));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_COLS: cols_reg = cfg_data[7:0];
          REG_SRC_ROWS: rows_reg = cfg_data[7:0];
          REG_SHIFT_X:  shift_x_reg = cfg_data[7:0];
          REG_SHIFT_Y:  shift_y_reg = cfg_data[7:0];
          REG_COS_Q14:  cos_reg = cfg_data;
          REG_SIN_Q14:  sin_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_WRITE)
          src_image[in_tdata[13:7] * SRC_DIM + in_tdata[6:0]] = in_tdata[21:14];
        else
          pending_px = {pending_px, rotated_sample(in_tdata[6:0], in_tdata[13:7])};
      end
    end
    awaiting = pending_px.size();
  end

endmodule

[dv/testbench.sv]
// testbench: stimulus and verdict for rotated_window_crop; checking sits in crop_checker
// depends on rwc_pkg, rwc_tb_pkg, crop_checker and the block itself
module testbench;
  import rwc_pkg::*;
  import rwc_tb_pkg::*;

  localparam int DRAIN_CYCLES    = 12;        // covers the block pipeline with margin
  localparam int HOLD_CYCLES     = 300;       // long output stall, fills the pipeline
  localparam int CYCLE_LIMIT     = 1_000_000; // watchdog limit on the whole run
  localparam int PHASES_PER_MODE = 8;
  localparam int N_PHASES        = 3 * PHASES_PER_MODE;
  localparam int ITEM_TARGET     = 1500;      // words over the whole run, fills included
  localparam int MIN_PER_PHASE   = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // col [6:0], row [13:7], in_pixel [21:14], zero [23:22]
  logic        in_tuser = 1'b0; // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // out_pixel [7:0]
  logic        out_tuser;       // in_window
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches, awaiting, results_checked;

  // idle rates in percent, and long stalls asked of the receiver
  int send_idle = 0;
  int recv_idle = 0;
  int holds_asked = 0;

  int n_writes = 0;
  int n_requests = 0;
  int n_settings = 0;
  int cycles = 0;

  // which source pixels have been written so far; a request may only land on these
  bit loaded [128][128];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rotated_window_crop dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  crop_checker crop_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .results_checked (results_checked)
  );

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped by watchdog after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls at the current rate, plus long holds on request,
  // counted here so the sender keeps offering words meanwhile
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < holds_asked) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // one word on the input channel; valid stays high into the next word unless a gap falls
  task automatic send_word(input pixel_op_e op, input int col, input int row, input int grey);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, grey[7:0], row[6:0], col[6:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_WRITE) begin
      loaded[row][col] = 1'b1;
      n_writes++;
    end else begin
      n_requests++;
    end
  endtask

  // wait until every result is back, then let any trailing writes leave the pipeline
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write every source pixel the current image size can reach, once
  task automatic ensure_source(input logic [7:0] c, input logic [7:0] r);
    int nc, nr, i, j;
    nc = (c == 0) ? 1 : ((c > 128) ? 128 : int'(c));
    nr = (r == 0) ? 1 : ((r > 128) ? 128 : int'(r));
    for (i = 0; i < nr; i++)
      for (j = 0; j < nc; j++)
        if (!loaded[i][j]) send_word(OP_WRITE, j, i, $urandom_range(255));
  endtask

  // new register setting, only once the block has gone quiet
  task automatic load_setting(input logic [7:0] c, input logic [7:0] r,
                              input logic [7:0] sx, input logic [7:0] sy,
                              input logic [15:0] cs, input logic [15:0] sn);
    settle();
    put_reg(REG_SRC_COLS, {8'd0, c});
    put_reg(REG_SRC_ROWS, {8'd0, r});
    put_reg(REG_SHIFT_X, {8'd0, sx});
    put_reg(REG_SHIFT_Y, {8'd0, sy});
    put_reg(REG_COS_Q14, cs);
    put_reg(REG_SIN_Q14, sn);
    cfg_valid <= 1'b0;
    n_settings++;
    ensure_source(c, r);
  endtask

  // image size register: mostly small, some up to full, some out of range
  function automatic logic [7:0] pick_size();
    int k;
    k = $urandom_range(9);
    if (k < 6) return 8'($urandom_range(2, 24));
    if (k < 8) return 8'($urandom_range(25, 128));
    if (k == 8) begin
      case ($urandom_range(2))
        0: return 8'd0;
        1: return 8'd1;
        default: return 8'd128;
      endcase
    end
    return 8'($urandom_range(129, 255));
  endfunction

  function automatic logic [7:0] pick_shift();
    int k;
    k = $urandom_range(9);
    if (k < 6) return 8'($urandom_range(16) - 8);
    if (k < 8) return 8'($urandom_range(128) - 64);
    if (k == 8) return $urandom_range(1) ? 8'd64 : 8'hC0;
    return 8'($urandom_range(255));
  endfunction

  // cosine or sine: within +-1, exactly 0 or +-1, or anything the 16 bits hold
  function automatic logic [15:0] pick_trig();
    int k;
    k = $urandom_range(9);
    if (k < 4) return 16'($urandom_range(32768) - 16384);
    if (k < 6) begin
      case ($urandom_range(2))
        0: return 16'h4000;
        1: return 16'hC000;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom_range(65535));
  endfunction

  // a quarter writes anywhere, the rest requests mostly near the window
  task automatic random_item();
    if ($urandom_range(3) == 0)
      send_word(OP_WRITE, $urandom_range(127), $urandom_range(127), $urandom_range(255));
    else if ($urandom_range(4) == 0)
      send_word(OP_REQUEST, $urandom_range(127), $urandom_range(127), $urandom_range(255));
    else
      send_word(OP_REQUEST, $urandom_range(47), $urandom_range(47), $urandom_range(255));
  endtask

  initial begin : stimulus
    int mode, ph, k;
    logic [7:0] c, r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // 4x4 image scaled by 1.5: ties at half a pixel on both axes, rounding onto the
    // last column and row, positions left of and above the image
    load_setting(8'd4, 8'd4, 8'd0, 8'd0, 16'd24576, 16'd0);
    send_word(OP_WRITE, 0, 0, 0);
    send_word(OP_WRITE, 3, 3, 255);
    send_word(OP_WRITE, 127, 127, 255);
    send_word(OP_REQUEST, 3, 2, 0);       // tie rounds up to the edge, clamped back
    send_word(OP_REQUEST, 1, 1, 0);       // ties to even land on the first pixel
    send_word(OP_REQUEST, 0, 2, 0);       // left of the source
    send_word(OP_REQUEST, 2, 0, 0);       // above the source
    send_word(OP_REQUEST, 3, 3, 255);
    send_word(OP_REQUEST, 2, 2, 0);
    send_word(OP_REQUEST, 4, 0, 0);       // past the window edge
    send_word(OP_REQUEST, 127, 127, 255);

    // scale just under 2: rounds past the last column without a tie
    load_setting(8'd4, 8'd4, 8'd0, 8'd0, 16'd30000, 16'd0);
    send_word(OP_REQUEST, 3, 3, 0);

    // shifts far beyond the image leave no window at all
    load_setting(8'd4, 8'd4, 8'd127, 8'h80, 16'h4000, 16'h0000);
    send_word(OP_REQUEST, 0, 0, 0);
    send_word(OP_REQUEST, 3, 3, 0);

    // sizes out of range: 255 columns act as 128, 0 rows as 1
    load_setting(8'd255, 8'd0, 8'hD4, 8'd0, 16'h4000, 16'h0000);
    send_word(OP_REQUEST, 0, 0, 0);
    send_word(OP_REQUEST, 39, 0, 0);
    send_word(OP_REQUEST, 40, 0, 0);
    send_word(OP_REQUEST, 0, 1, 0);

    // single pixel image under a 135 degree turn with a scale of root two
    load_setting(8'd0, 8'd1, 8'd0, 8'd0, 16'hC000, 16'h4000);
    send_word(OP_REQUEST, 0, 0, 0);

    // random settings under three idling regimes, one long output hold in each
    for (mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 15 : ((mode == 1) ? 50 : 0);
      recv_idle = (mode == 0) ? 50 : ((mode == 1) ? 15 : 0);
      for (ph = 0; ph < PHASES_PER_MODE; ph++) begin
        c = pick_size();
        r = pick_size();
        // a wide image stays a short strip and a tall one a narrow strip,
        // so the source fill stays small
        if (c > 8'd24 && r > 8'd2) r = 8'($urandom_range(2));
        else if (r > 8'd24 && c > 8'd2) c = 8'($urandom_range(2));
        load_setting(c, r, pick_shift(), pick_shift(), pick_trig(), pick_trig());
        if (ph == 2) holds_asked++;
        k = 0;
        while (k < MIN_PER_PHASE ||
               n_writes + n_requests <
               (mode * PHASES_PER_MODE + ph + 1) * ITEM_TARGET / N_PHASES) begin
          random_item();
          k++;
        end
      end
    end

    settle();
    @(negedge clk);
    $display("covered %0d pixel writes and %0d window requests over %0d register settings,",
             n_writes, n_requests, n_settings);
    $display("with %0d results compared and %0d long output holds", results_checked,
             holds_asked);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
